/* src/oal_pkg.sv */
// Shared types and codes for the ordered array list.
package oal_pkg;

    // Operation codes carried on s_tuser
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_FIND   = 2'd2
    } op_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;   // shift up from position, load new value at position
        logic del;   // shift down from position
        logic cap;   // capture match flag against the search key
    } cell_ctrl_t;

    // Scanner status toward the controller
    typedef struct packed {
        logic done;
        logic hit;
    } scan_stat_t;

    localparam int GROUP = 8;  // match flags examined per scan cycle

endpackage

/* src/oal_cell.sv */
// One list slot: holds an entry, shifts with its neighbors, flags a key match.
module oal_cell #(
    parameter int IDX = 0,
    parameter int WW  = 8
) (
    input  logic                   aclk,
    input  oal_pkg::cell_ctrl_t    ctrl,
    input  logic [WW-1:0]          pos_w,
    input  logic [WW-1:0]          count_w,
    input  logic signed [31:0]     new_value,
    input  logic signed [31:0]     left_value,
    input  logic signed [31:0]     right_value,
    output logic signed [31:0]     value,
    output logic                   match
);
    import oal_pkg::*;

    logic signed [31:0] value_reg, value_next;
    logic               match_reg, match_next;

    always_comb begin
        value_next = value_reg;
        match_next = match_reg;
        if (ctrl.ins) begin
            if (WW'(IDX) == pos_w) begin
                value_next = new_value;
            end else if (WW'(IDX) > pos_w) begin
                value_next = left_value;
            end
        end else if (ctrl.del) begin
            if (WW'(IDX) >= pos_w) begin
                value_next = right_value;
            end
        end
        if (ctrl.cap) begin
            match_next = (value_reg == new_value) && (WW'(IDX) < count_w);
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        match_reg <= match_next;
    end

    assign value = value_reg;
    assign match = match_reg;

endmodule

/* src/oal_scan.sv */
// Lowest-set-bit search over the cell match flags, one group per cycle.
module oal_scan #(
    parameter int NG = 16,
    parameter int GW = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        run,
    input  logic [NG*oal_pkg::GROUP-1:0] match_vec,
    output oal_pkg::scan_stat_t         stat,
    output logic [GW+2:0]               hit_idx
);
    import oal_pkg::*;

    logic [GW-1:0]    grp_reg, grp_next;
    logic [GROUP-1:0] flags;
    logic [2:0]       off;

    assign flags = match_vec[grp_reg*GROUP +: GROUP];

    // priority encode, lowest index wins
    always_comb begin
        off = 3'd0;
        for (int k = GROUP - 1; k >= 0; k--) begin
            if (flags[k]) begin
                off = 3'(k);
            end
        end
    end

    always_comb begin
        stat.hit  = |flags;
        stat.done = run && ((|flags) || (grp_reg == GW'(NG - 1)));
        hit_idx   = {grp_reg, off};
        grp_next  = grp_reg;
        if (!run || stat.done) begin
            grp_next = '0;
        end else begin
            grp_next = grp_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_reg <= '0;
        end else begin
            grp_reg <= grp_next;
        end
    end

endmodule

/* src/ordered_array_list.sv */
// Top level of the ordered array list: cell chain, match scanner, controller.
//
//  channel | dir | ports                       | item contents
//  --------+-----+-----------------------------+--------------------------------------
//  s_      | in  | tvalid tready tdata tuser   | operation, position, value
//  m_      | out | tvalid tready tdata tuser   | status, found_position, count
//
//  Insert, delete and unused codes load the result from the idle state; the next
//  item can be taken in the following cycle once the result register is free or
//  being drained. Find has every cell compare at once, then the scanner walks the
//  match flags 8 cells per cycle until the first hit or the last group.
//  Reset clears the entry count, controller and result valid; cell contents are
//  left as they are and only entries below the count are ever looked at.
//  m_tready low holds the result; s_tready stays low until it can be replaced.
module ordered_array_list #(
    parameter int CAPACITY = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position[7:0], value[39:8]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // found_position[6:0], count[14:7], zero[15]
    output logic [0:0]  m_tuser    // status[0]
);
    import oal_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);       // entry count width
    localparam int WW = (CW > 8) ? CW : 8;          // compare width for position/count
    localparam int NG = (CAPACITY + GROUP - 1) / GROUP;
    localparam int GW = (NG > 1) ? $clog2(NG) : 1;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic            status_reg, status_next;
    logic [6:0]      found_reg, found_next;
    logic [7:0]      out_count_reg, out_count_next;

    cell_ctrl_t      ctrl;
    scan_stat_t      scan_stat;
    logic            scan_run;
    logic [GW+2:0]   hit_idx;
    logic            s_accept;
    op_t             op;
    logic [7:0]      pos_in;
    logic signed [31:0] value_in;
    logic [WW-1:0]   pos_w, count_w;
    logic            ins_ok, del_ok;

    logic signed [31:0]        cell_value [CAPACITY];
    logic [NG*GROUP-1:0]       match_vec;

    assign op       = op_t'(s_tuser);
    assign pos_in   = s_tdata[7:0];
    assign value_in = s_tdata[39:8];
    assign pos_w    = WW'(pos_in);
    assign count_w  = WW'(count_reg);

    // a new item only enters while idle and when the result slot is free at this edge
    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;

    assign ins_ok = (pos_w <= count_w) && (count_w < WW'(CAPACITY));
    assign del_ok = (pos_w < count_w);

    // ---- cell chain ----
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [31:0] left_v, right_v;
        if (i == 0) begin : g_first
            assign left_v = '0;
        end else begin : g_mid_l
            assign left_v = cell_value[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_v = '0;
        end else begin : g_mid_r
            assign right_v = cell_value[i+1];
        end
        oal_cell #(
            .IDX (i),
            .WW  (WW)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .pos_w       (pos_w),
            .count_w     (count_w),
            .new_value   (value_in),
            .left_value  (left_v),
            .right_value (right_v),
            .value       (cell_value[i]),
            .match       (match_vec[i])
        );
    end

    // pad flags beyond the last cell
    if (NG * GROUP > CAPACITY) begin : g_pad
        assign match_vec[NG*GROUP-1:CAPACITY] = '0;
    end

    // ---- match scanner ----
    oal_scan #(
        .NG (NG),
        .GW (GW)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .run       (scan_run),
        .match_vec (match_vec),
        .stat      (scan_stat),
        .hit_idx   (hit_idx)
    );

    // ---- controller ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg    <= status_next;
        found_reg     <= found_next;
        out_count_reg <= out_count_next;
    end

    always_comb begin
        logic            load;
        logic [CW+7:0]   count_ext;
        logic [GW+9:0]   idx_ext;

        load           = 1'b0;
        state_next     = state_reg;
        count_next     = count_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        status_next    = status_reg;
        found_next     = found_reg;
        out_count_next = out_count_reg;
        ctrl           = '0;
        scan_run       = 1'b0;
        idx_ext        = {7'd0, hit_idx};

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (op)
                        OP_INSERT: begin
                            load        = 1'b1;
                            found_next  = 7'd0;
                            status_next = !ins_ok;
                            if (ins_ok) begin
                                ctrl.ins   = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_DELETE: begin
                            load        = 1'b1;
                            found_next  = 7'd0;
                            status_next = !del_ok;
                            if (del_ok) begin
                                ctrl.del   = 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_FIND: begin
                            ctrl.cap   = 1'b1;
                            state_next = ST_SCAN;
                        end
                        default: begin
                            load        = 1'b1;
                            found_next  = 7'd0;
                            status_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                scan_run = 1'b1;
                if (scan_stat.done) begin
                    load        = 1'b1;
                    status_next = !scan_stat.hit;
                    found_next  = scan_stat.hit ? idx_ext[6:0] : 7'd0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        count_ext = {8'd0, count_next};
        if (load) begin
            m_tvalid_next  = 1'b1;
            out_count_next = count_ext[7:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_count_reg, found_reg};
    assign m_tuser  = status_reg;

`ifndef ASSERT_OFF
    // list never grows beyond its capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    // while a find is scanning, no new item enters
    a_scan_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !s_tready)
        else $error("item accepted during scan");

    // the result slot is empty throughout a scan
    a_scan_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !m_tvalid_reg)
        else $error("result pending during scan");

    // count moves only on an accepted item
    a_count_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(count_reg))
        else $error("count changed without an item");
`endif

endmodule
